>>> rtl/salc_pkg.sv
`default_nettype none

package salc_pkg;

  // Width of the address field on the request channel.
  localparam int ADDRESS_W = 48;

  // Width of a way age and of the per-set clock.
  localparam int AGE_W = 8;

  // Dividend bits fed to the reciprocal multiplier per cycle.
  localparam int DIV_CHUNK_W = 16;

endpackage

`default_nettype wire

>>> rtl/salc_ifs.sv
`default_nettype none

interface salc_addr_if import salc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDRESS_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface salc_hit_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

`default_nettype wire

>>> rtl/set_assoc_lru_cache_hit_model.sv
// Tag-only set-associative cache with age-based LRU replacement.
//
// The request channel (access) carries one byte address per transfer; the
// response channel (result) returns one hit flag per address, in order.
// The block handles one address at a time: access.ready is high only while
// the sequencer is idle, but a new address is taken while a finished hit
// flag is still waiting in the output register.
//
// With LINE_BYTES and SETS powers of two, one address goes through a row
// read, a scan of the ways through the shared tag and age comparator, a row
// write and a return to idle. When a set's clock wraps, the ages are
// re-ranked one way per cycle before the row write. A LINE_BYTES or SETS that
// is not a power of two goes through the shared reciprocal multiplier first.
//
// After reset the block writes the reset value into every set, one set per
// cycle, before the first address is taken. When the receiver stalls, the
// hit flag is held and the block stops after its next address until the flag
// has been taken.
`default_nettype none

module set_assoc_lru_cache_hit_model import salc_pkg::*; #(
  parameter int WAYS       = 8,
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 48
) (
  input wire logic   clk,
  input wire logic   rst,
  salc_addr_if.sink  access,
  salc_hit_if.source result
);

  localparam int A_W       = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int LB_LOG    = $clog2(LINE_BYTES + 1) - 1;
  localparam bit LB_POW2   = (LINE_BYTES == (1 << LB_LOG));
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int LINE_W    = A_W - LB_LOG;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = $clog2(WAYS);
  localparam int AGES_LO   = WAYS * LINE_W;
  localparam int CLOCK_LO  = WAYS * (LINE_W + AGE_W);
  localparam int ROW_W     = CLOCK_LO + AGE_W;
  localparam int DIV_LB_W  = $clog2(LINE_BYTES + 1);
  localparam int DIV_S_W   = $clog2(SETS + 1);
  localparam int DIV_W     = (DIV_LB_W > DIV_S_W) ? DIV_LB_W : DIV_S_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIVL  = 9'b000000100,
    S_DIVS  = 9'b000001000,
    S_READ  = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_RANK  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic             accept;
  logic [A_W-1:0]   addr_eff;
  logic [LINE_W-1:0] acc_line;
  logic [LINE_W-1:0] line_src;
  logic [SET_W-1:0] set_pow2;
  logic [SET_W-1:0] clr_cnt;
  logic [WAY_W-1:0] cnt;
  logic             cnt_last;
  logic             load_out;

  logic [LINE_W-1:0] line_r;
  logic [SET_W-1:0]  set_r;
  logic              hit_r;

  logic             div_start;
  logic             div_sel;
  logic [A_W-1:0]   div_dividend;
  logic             div_done;
  logic [A_W-1:0]   div_quot;
  logic [DIV_W-1:0] div_rem;

  logic             ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] reset_row;
  logic [ROW_W-1:0] work_row;

  logic [LINE_W-1:0] rd_tags [WAYS];
  logic [AGE_W-1:0]  rd_ages [WAYS];
  logic [AGE_W-1:0]  rd_clock;

  logic [LINE_W-1:0] tags_w [WAYS];
  logic [AGE_W-1:0]  ages_w [WAYS];
  logic [AGE_W-1:0]  rank_w [WAYS];
  logic [AGE_W-1:0]  clock_w;

  logic             hit_f;
  logic [WAY_W-1:0] hit_way;
  logic [AGE_W-1:0] min_age;
  logic [WAY_W-1:0] min_way;

  logic             s_hit;
  logic [WAY_W-1:0] s_hit_way;
  logic [AGE_W-1:0] s_min_age;
  logic [WAY_W-1:0] s_min_way;
  logic [WAY_W-1:0] sel_way;
  logic [AGE_W-1:0] clock_inc;
  logic [AGE_W-1:0] rank_val;

  assign access.ready = (state == S_IDLE);
  assign accept       = access.valid & access.ready;
  assign addr_eff     = access.address[A_W-1:0];
  assign acc_line     = LINE_W'(addr_eff >> LB_LOG);
  assign line_src     = (state == S_IDLE) ? acc_line : LINE_W'(div_quot);
  assign set_pow2     = SET_W'(line_src & LINE_W'(SETS - 1));
  assign cnt_last     = (cnt == WAY_W'(WAYS - 1));
  assign load_out     = (state == S_WRITE || state == S_DONE) &&
                        (!result.valid || result.ready);

  // The divider yields the line index if LINE_BYTES is not a power of two, then the set as a remainder if SETS is not.
  always_comb begin
    div_start    = 1'b0;
    div_sel      = 1'b0;
    div_dividend = '0;
    if (state == S_IDLE && accept && !LB_POW2) begin
      div_start    = 1'b1;
      div_dividend = addr_eff;
    end else if (state == S_IDLE && accept && !SETS_POW2) begin
      div_start    = 1'b1;
      div_sel      = 1'b1;
      div_dividend = A_W'(acc_line);
    end else if (state == S_DIVL && div_done && !SETS_POW2) begin
      div_start    = 1'b1;
      div_sel      = 1'b1;
      div_dividend = div_quot;
    end
  end

  salc_div #(
    .DIVIDEND_W (A_W),
    .DIVISOR_A  (LINE_BYTES),
    .DIVISOR_B  (SETS),
    .REM_W      (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .sel       (div_sel),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // One row per set: the tags, the ages and the set's clock.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rd_tags[w] = rd_data[w*LINE_W +: LINE_W];
      rd_ages[w] = rd_data[AGES_LO + w*AGE_W +: AGE_W];
      reset_row[w*LINE_W +: LINE_W]          = '0;
      reset_row[AGES_LO + w*AGE_W +: AGE_W]  = AGE_W'(w);
      work_row[w*LINE_W +: LINE_W]           = tags_w[w];
      work_row[AGES_LO + w*AGE_W +: AGE_W]   = ages_w[w];
    end
    rd_clock                         = rd_data[CLOCK_LO +: AGE_W];
    reset_row[CLOCK_LO +: AGE_W]     = AGE_W'(WAYS);
    work_row[CLOCK_LO +: AGE_W]      = clock_w;
  end

  assign ram_wr_en   = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_wr_addr = (state == S_CLEAR) ? clr_cnt : set_r;
  assign ram_wr_data = (state == S_CLEAR) ? reset_row : work_row;
  assign ram_rd_en   = (state == S_READ);

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (set_r),
    .rd_data (rd_data)
  );

  // One way per cycle: tag match with the lowest matching way kept, and the
  // lowest age with the lowest way kept on a tie.
  always_comb begin
    if (cnt == '0) begin
      s_hit     = (rd_tags[cnt] == line_r);
      s_hit_way = '0;
      s_min_age = rd_ages[cnt];
      s_min_way = '0;
    end else begin
      s_hit     = hit_f | (rd_tags[cnt] == line_r);
      s_hit_way = hit_f ? hit_way : cnt;
      if (rd_ages[cnt] < min_age) begin
        s_min_age = rd_ages[cnt];
        s_min_way = cnt;
      end else begin
        s_min_age = min_age;
        s_min_way = min_way;
      end
    end
    sel_way   = s_hit ? s_hit_way : s_min_way;
    clock_inc = rd_clock + AGE_W'(1);
  end

  // Rank of one way among the set's ages, ties broken by way order.
  always_comb begin
    rank_val = '0;
    for (int v = 0; v < WAYS; v++) begin
      if ((ages_w[v] < ages_w[cnt]) ||
          (ages_w[v] == ages_w[cnt] && WAY_W'(v) < cnt)) begin
        rank_val = rank_val + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      cnt          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SET_W'(1);
          if (clr_cnt == SET_W'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!LB_POW2) begin
              state <= S_DIVL;
            end else if (!SETS_POW2) begin
              state <= S_DIVS;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_DIVL: begin
          if (div_done) begin
            state <= SETS_POW2 ? S_READ : S_DIVS;
          end
        end
        S_DIVS: begin
          if (div_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          cnt   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt_last) begin
            cnt   <= '0;
            state <= (clock_inc == '0) ? S_RANK : S_WRITE;
          end else begin
            cnt <= cnt + WAY_W'(1);
          end
        end
        S_RANK: begin
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_WRITE;
          end else begin
            cnt <= cnt + WAY_W'(1);
          end
        end
        S_WRITE: begin
          state <= load_out ? S_IDLE : S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && LB_POW2) begin
      line_r <= acc_line;
      if (SETS_POW2) begin
        set_r <= set_pow2;
      end
    end
    if (state == S_DIVL && div_done) begin
      line_r <= LINE_W'(div_quot);
      if (SETS_POW2) begin
        set_r <= set_pow2;
      end
    end
    if (state == S_DIVS && div_done) begin
      set_r <= SET_W'(div_rem);
    end

    if (state == S_SCAN) begin
      hit_f   <= s_hit;
      hit_way <= s_hit_way;
      min_age <= s_min_age;
      min_way <= s_min_way;
      if (cnt_last) begin
        hit_r <= s_hit;
        for (int w = 0; w < WAYS; w++) begin
          tags_w[w] <= (!s_hit && WAY_W'(w) == sel_way) ? line_r : rd_tags[w];
          ages_w[w] <= (WAY_W'(w) == sel_way) ? rd_clock : rd_ages[w];
        end
        clock_w <= clock_inc;
      end
    end

    if (state == S_RANK) begin
      rank_w[cnt] <= rank_val;
      if (cnt_last) begin
        for (int w = 0; w < WAYS; w++) begin
          ages_w[w] <= (WAY_W'(w) == cnt) ? rank_val : rank_w[w];
        end
        clock_w <= AGE_W'(WAYS);
      end
    end

    if (load_out) begin
      result.hit <= hit_r;
    end
  end

  // The output holds a valid hit flag, new or still held, the cycle after the row write.
  a_write_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> result.valid)
    else $error("hit flag not presented after the row write");

  // A finished division is only ever consumed by one of the divide states.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVL || state == S_DIVS))
    else $error("divider finished outside a divide state");

  // A wrapped clock is always replaced by WAYS before the row goes back.
  a_clock_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> clock_w != '0)
    else $error("set clock written back as zero");

  // Only one address is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !access.ready)
    else $error("second address taken while one is in progress");

endmodule

`default_nettype wire

>>> rtl/salc_ram.sv
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/salc_div.sv
`default_nettype none

module salc_div import salc_pkg::*; #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_A  = 64,
  parameter int DIVISOR_B  = 64,
  parameter int REM_W      = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  sel,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient,
  output logic      [REM_W-1:0]      remainder
);

  localparam int CHUNKS = (DIVIDEND_W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
  localparam int PAD_W  = CHUNKS * DIV_CHUNK_W;
  localparam int M_W    = PAD_W + 1;
  localparam int SUM_W  = M_W + DIV_CHUNK_W;
  localparam int CNT_W  = $clog2(CHUNKS + 1);
  localparam int L_A    = $clog2(DIVISOR_A);
  localparam int L_B    = $clog2(DIVISOR_B);

  // With m = floor(2^(PAD_W + l) / d) + 1 and 2^(l-1) < d <= 2^l, the top
  // bits of x * m give floor(x / d) exactly for every PAD_W-bit x.
  localparam longint unsigned M_A =
    ((64'd1 << (PAD_W + L_A)) / 64'(DIVISOR_A)) + 64'd1;
  localparam longint unsigned M_B =
    ((64'd1 << (PAD_W + L_B)) / 64'(DIVISOR_B)) + 64'd1;

  logic [PAD_W-1:0]       x;
  logic [REM_W-1:0]       x_low;
  logic                   use_b;
  logic [M_W-1:0]         acc;
  logic [M_W-1:0]         acc_next;
  logic [M_W-1:0]         m_sel;
  logic [REM_W-1:0]       d_sel;
  logic [DIV_CHUNK_W-1:0] chunk;
  logic [SUM_W-1:0]       prod;
  logic [SUM_W-1:0]       sum;
  logic [M_W-1:0]         q_val;
  logic [M_W-1:0]         q;
  logic [REM_W-1:0]       rem;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;

  assign m_sel = use_b ? M_W'(M_B) : M_W'(M_A);
  assign d_sel = use_b ? REM_W'(DIVISOR_B) : REM_W'(DIVISOR_A);
  assign chunk = x[DIV_CHUNK_W-1:0];

  // One dividend chunk per cycle, lowest first. Only the bits that are final
  // are shifted out, so the accumulator stays within the reciprocal's width.
  assign prod     = SUM_W'(chunk) * SUM_W'(m_sel);
  assign sum      = SUM_W'(acc) + prod;
  assign acc_next = M_W'(sum >> DIV_CHUNK_W);
  assign q_val    = use_b ? (acc >> L_B) : (acc >> L_A);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CHUNKS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x     <= PAD_W'(dividend);
      x_low <= REM_W'(dividend);
      use_b <= sel;
      acc   <= '0;
    end else if (busy) begin
      if (cnt != CNT_W'(CHUNKS)) begin
        acc <= acc_next;
        x   <= x >> DIV_CHUNK_W;
      end else begin
        // The remainder is below the divisor, so its low bits are enough.
        q   <= q_val;
        rem <= x_low - REM_W'(q_val) * d_sel;
      end
    end
  end

  assign quotient  = q[DIVIDEND_W-1:0];
  assign remainder = rem;

endmodule

`default_nettype wire
